FILE: sv/ramx_pkg.sv
// ============================================================================
// ramx_pkg
// Shared types and constants of the range arg-max segment tree.
// ============================================================================
package ramx_pkg;

    // Tree size and stored value width
    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 32;

    // Derived widths
    localparam int NODES  = 2 * LEAVES;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NIDX_W = $clog2(NODES);
    localparam int CNT_W  = NIDX_W + 1;

    // Port field widths
    localparam int ACTION_W = 1;
    localparam int POS_W    = 10;
    localparam int IN_VAL_W = 32;
    localparam int LOW_W    = 10;
    localparam int HIGH_W   = 11;
    localparam int IDX_W    = 10;
    localparam int OUT_VAL_W = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

    // One tree node: valid flag, leaf index of the maximum, and its value
    typedef struct packed {
        logic                         valid;
        logic [LEAF_W-1:0]            index;
        logic signed [VALUE_BITS-1:0] value;
    } t_node;

endpackage

FILE: sv/range_argmax_segment_tree.sv
// ============================================================================
// range_argmax_segment_tree
// Bottom-up segment tree with range arg-max queries over one node memory.
// ============================================================================
// After reset the block sweeps the node memory clear, one node per cycle;
// o_stall stays high until the sweep is done. A write beat keeps the block
// busy while it stores the leaf, then walks up one tree level at a time,
// each level reading the sibling node and writing the merged parent. A query
// beat keeps it busy while it walks one level at a time until the range
// bounds meet (no levels for an empty range), each level reading up to two
// nodes over the two read ports of the node memory; it then finishes the
// last merge and forms the result. o_stall stays high until the block is
// back in idle, so it takes no new beat before it is through with the last
// one. A finished result waits in the output register while the next beat
// is taken; a query stalls only if that register is still full and held by
// i_stall when its own result is ready. Writes give no result beat.
// ============================================================================
module range_argmax_segment_tree (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ramx_pkg::ACTION_W-1:0]         i_action,
    input  logic [ramx_pkg::POS_W-1:0]            i_position,
    input  logic signed [ramx_pkg::IN_VAL_W-1:0]  i_value,
    input  logic [ramx_pkg::LOW_W-1:0]            i_range_low,
    input  logic [ramx_pkg::HIGH_W-1:0]           i_range_high,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_found,
    output logic [ramx_pkg::IDX_W-1:0]            o_max_index,
    output logic signed [ramx_pkg::OUT_VAL_W-1:0] o_max_value
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_LEAF,
        ST_W_UP,
        ST_Q_WALK,
        ST_Q_DONE
    } t_state;

    // State and registers
    t_state                          r_state, n_state;
    logic [ramx_pkg::NIDX_W-1:0]     r_clr, n_clr;
    logic [ramx_pkg::NIDX_W-1:0]     r_k, n_k;
    ramx_pkg::t_node                 r_cur, n_cur;
    logic [ramx_pkg::CNT_W-1:0]      r_lo, n_lo;
    logic [ramx_pkg::CNT_W-1:0]      r_hi, n_hi;
    logic                            r_use_l, n_use_l;
    logic                            r_use_r, n_use_r;
    ramx_pkg::t_node                 r_left, n_left;
    ramx_pkg::t_node                 r_right, n_right;
    logic                            r_out_valid, n_out_valid;
    logic                            r_found, n_found;
    logic [ramx_pkg::IDX_W-1:0]      r_max_index, n_max_index;
    logic signed [ramx_pkg::OUT_VAL_W-1:0] r_max_value, n_max_value;

    // Node memory and its ports
    ramx_pkg::t_node                 r_mem [ramx_pkg::NODES];
    ramx_pkg::t_node                 r_rd_a, r_rd_b;
    logic                            mem_we;
    logic [ramx_pkg::NIDX_W-1:0]     mem_waddr;
    ramx_pkg::t_node                 mem_wdata;
    logic [ramx_pkg::NIDX_W-1:0]     rd_addr_a, rd_addr_b;

    // Merge results
    ramx_pkg::t_node                 up_l, up_r, merged_up;
    ramx_pkg::t_node                 merged_l, merged_r, merged_best;

    // Walk helpers
    logic                            in_accept;
    logic                            walk_go;
    logic                            lo_odd, hi_odd;
    logic [ramx_pkg::CNT_W-1:0]      lo1, hi1;
    logic [ramx_pkg::NIDX_W-1:0]     parent;
    logic [ramx_pkg::CNT_W-1:0]      hi_clamp;

    assign in_accept = i_valid && (r_state == ST_IDLE);
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_max_index = r_max_index;
    assign o_max_value = r_max_value;

    // Order the running node and its sibling by position in the tree
    assign up_l = r_k[0] ? r_rd_a : r_cur;
    assign up_r = r_k[0] ? r_cur : r_rd_a;

    ramx_merge u_merge_up (
        .i_a (up_l),
        .i_b (up_r),
        .o_y (merged_up)
    );

    ramx_merge u_merge_l (
        .i_a (r_left),
        .i_b (r_rd_a),
        .o_y (merged_l)
    );

    ramx_merge u_merge_r (
        .i_a (r_rd_b),
        .i_b (r_right),
        .o_y (merged_r)
    );

    ramx_merge u_merge_best (
        .i_a (r_left),
        .i_b (r_right),
        .o_y (merged_best)
    );

    // Query level step
    assign walk_go = (r_lo < r_hi);
    assign lo_odd  = r_lo[0];
    assign hi_odd  = r_hi[0];
    assign lo1     = r_lo + ramx_pkg::CNT_W'(lo_odd);
    assign hi1     = r_hi - ramx_pkg::CNT_W'(hi_odd);
    assign parent  = r_k >> 1;

    // Clamp the query end to the leaf count
    assign hi_clamp = (32'(i_range_high) > ramx_pkg::LEAVES) ?
                      ramx_pkg::CNT_W'(ramx_pkg::LEAVES) :
                      ramx_pkg::CNT_W'(i_range_high);

    // Next-state and memory control
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_k         = r_k;
        n_cur       = r_cur;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_use_l     = r_use_l;
        n_use_r     = r_use_r;
        n_left      = r_left;
        n_right     = r_right;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_max_index = r_max_index;
        n_max_value = r_max_value;
        mem_we      = 1'b0;
        mem_waddr   = r_k;
        mem_wdata   = r_cur;
        rd_addr_a   = '0;
        rd_addr_b   = '0;

        // drop the result beat once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + ramx_pkg::NIDX_W'(1);
                if (r_clr == ramx_pkg::NIDX_W'(ramx_pkg::NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_action == ramx_pkg::ACT_WRITE) begin
                        // out-of-range writes are dropped
                        if (32'(i_position) < ramx_pkg::LEAVES) begin
                            n_cur.valid = 1'b1;
                            n_cur.index = ramx_pkg::LEAF_W'(i_position);
                            n_cur.value = ramx_pkg::VALUE_BITS'($unsigned(i_value));
                            n_k         = ramx_pkg::NIDX_W'(32'(i_position)
                                                            + ramx_pkg::LEAVES);
                            n_state     = ST_W_LEAF;
                        end
                    end else begin
                        n_use_l = 1'b0;
                        n_use_r = 1'b0;
                        n_left  = '0;
                        n_right = '0;
                        if (32'(i_range_low) < 32'(hi_clamp)) begin
                            n_lo = ramx_pkg::CNT_W'(32'(i_range_low) + ramx_pkg::LEAVES);
                            n_hi = hi_clamp + ramx_pkg::CNT_W'(ramx_pkg::LEAVES);
                        end else begin
                            n_lo = '0;
                            n_hi = '0;
                        end
                        n_state = ST_Q_WALK;
                    end
                end
            end
            ST_W_LEAF: begin
                // store the leaf, fetch its sibling
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = r_cur;
                rd_addr_a = r_k ^ ramx_pkg::NIDX_W'(1);
                n_state   = ST_W_UP;
            end
            ST_W_UP: begin
                // write the merged parent, fetch the next sibling
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = merged_up;
                n_cur     = merged_up;
                n_k       = parent;
                if (parent == ramx_pkg::NIDX_W'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    rd_addr_a = parent ^ ramx_pkg::NIDX_W'(1);
                end
            end
            ST_Q_WALK: begin
                // fold in nodes read on the previous level
                if (r_use_l) begin
                    n_left = merged_l;
                end
                if (r_use_r) begin
                    n_right = merged_r;
                end
                if (walk_go) begin
                    rd_addr_a = ramx_pkg::NIDX_W'(r_lo);
                    rd_addr_b = ramx_pkg::NIDX_W'(hi1);
                    n_use_l   = lo_odd;
                    n_use_r   = hi_odd;
                    n_lo      = lo1 >> 1;
                    n_hi      = hi1 >> 1;
                end else begin
                    n_use_l = 1'b0;
                    n_use_r = 1'b0;
                    n_state = ST_Q_DONE;
                end
            end
            ST_Q_DONE: begin
                // load the result once the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    if (merged_best.valid) begin
                        n_found     = 1'b1;
                        n_max_index = ramx_pkg::IDX_W'(merged_best.index);
                        n_max_value = ramx_pkg::OUT_VAL_W'($signed(merged_best.value));
                    end else begin
                        n_found     = 1'b0;
                        n_max_index = '0;
                        n_max_value = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Node memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_use_l     <= 1'b0;
            r_use_r     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_use_l     <= n_use_l;
            r_use_r     <= n_use_r;
            r_out_valid <= n_out_valid;
        end
        r_k         <= n_k;
        r_cur       <= n_cur;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_left      <= n_left;
        r_right     <= n_right;
        r_found     <= n_found;
        r_max_index <= n_max_index;
        r_max_value <= n_max_value;
    end

endmodule

FILE: sv/ramx_merge.sv
// ============================================================================
// ramx_merge
// Combine two tree nodes: keep the larger value, the lower index on a tie;
// an empty node gives way to the other one.
// ============================================================================
module ramx_merge (
    input  ramx_pkg::t_node i_a,
    input  ramx_pkg::t_node i_b,
    output ramx_pkg::t_node o_y
);

    // Select the winner
    always_comb begin
        if (!i_a.valid) begin
            o_y = i_b;
        end else if (!i_b.valid) begin
            o_y = i_a;
        end else if ($signed(i_a.value) > $signed(i_b.value)) begin
            o_y = i_a;
        end else if ($signed(i_b.value) > $signed(i_a.value)) begin
            o_y = i_b;
        end else if (i_a.index <= i_b.index) begin
            o_y = i_a;
        end else begin
            o_y = i_b;
        end
    end

endmodule
